// ----- sv/i2ctbc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C target byte controller package
// Shared constants, codes and types for the byte sequencer and its FIFOs.
// ----------------------------------------------------------------------------
package i2ctbc_pkg;

    localparam int RX_DEPTH = 16;
    localparam int TX_DEPTH = 16;
    localparam int RX_AW    = $clog2(RX_DEPTH);
    localparam int TX_AW    = $clog2(TX_DEPTH);
    localparam int RX_LW    = $clog2(RX_DEPTH + 1);
    localparam int TX_LW    = $clog2(TX_DEPTH + 1);
    localparam int LEVEL_W  = 5;
    localparam int ADDR_W   = 6;
    localparam int BYTE_W   = 8;
    localparam int BITS_W   = 4;

    localparam logic [BITS_W-1:0] BITS_ACK  = 4'd1;
    localparam logic [BITS_W-1:0] BITS_BYTE = 4'd8;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_SHIFT = 2'd1,
        CMD_PUSH  = 2'd2,
        CMD_POP   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        PH_ADDR      = 3'd0,
        PH_SEND      = 3'd1,
        PH_REQ_REPLY = 3'd2,
        PH_CHK_REPLY = 3'd3,
        PH_REQ_DATA  = 3'd4,
        PH_GET_DATA  = 3'd5
    } t_phase;

    typedef struct packed {
        logic               load_shift;
        logic               use_tx;
        logic               sda_drive;
        logic [BITS_W-1:0]  shift_bits;
        logic               wait_for_start;
        logic               read_request;
        logic               pop_valid;
        logic               push_dropped;
        logic               rx_overrun;
        logic [LEVEL_W-1:0] rx_level;
        logic [LEVEL_W-1:0] tx_level;
    } t_result;

endpackage

// ----- sv/i2c_target_byte_controller_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C target byte controller
// Byte-level target sequencer with receive and transmit FIFOs in RAM.
// ----------------------------------------------------------------------------
// channel   direction  handshake                      payload
// item      in         start & !busy                  i_command, i_shift_byte,
//                                                     i_stop_seen, i_host_byte
// result    out        o_result_valid, one cycle      o_load_shift .. o_tx_level
// config    in         i_cfg_we                       i_cfg_wdata (own address)
//
// One item per cycle; its result appears the cycle after acceptance, when the
// registered FIFO RAM read returns the popped or transmitted byte.
// busy is high only while reset is applied and the cycle after.
// Results cannot be stalled; reset clears pointers, phase, own address and bus arming.
// ----------------------------------------------------------------------------
module i2c_target_byte_controller_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_shift_byte,
    input  logic        i_stop_seen,
    input  logic [7:0]  i_host_byte,
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_wdata,
    output logic        o_result_valid,
    output logic        o_load_shift,
    output logic [7:0]  o_shift_value,
    output logic        o_sda_drive,
    output logic [3:0]  o_shift_bits,
    output logic        o_wait_for_start,
    output logic        o_read_request,
    output logic        o_pop_valid,
    output logic [7:0]  o_pop_byte,
    output logic        o_push_dropped,
    output logic        o_rx_overrun,
    output logic [4:0]  o_rx_level,
    output logic [4:0]  o_tx_level
);

    logic                           r_live;
    logic                           r_valid;
    i2ctbc_pkg::t_result            r_res;
    i2ctbc_pkg::t_result            res;
    logic                           accept;
    logic                           rx_we, tx_we;
    logic [i2ctbc_pkg::RX_AW-1:0]   rx_waddr, rx_raddr;
    logic [i2ctbc_pkg::TX_AW-1:0]   tx_waddr, tx_raddr;
    logic [7:0]                     rx_wdata, tx_wdata, rx_rdata, tx_rdata;

    assign busy   = !r_live;
    assign accept = start && !busy;

    i2ctbc_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_command    (i2ctbc_pkg::t_cmd'(i_command)),
        .i_shift_byte (i_shift_byte),
        .i_stop_seen  (i_stop_seen),
        .i_host_byte  (i_host_byte),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_result     (res),
        .o_rx_we      (rx_we),
        .o_rx_waddr   (rx_waddr),
        .o_rx_wdata   (rx_wdata),
        .o_rx_raddr   (rx_raddr),
        .o_tx_we      (tx_we),
        .o_tx_waddr   (tx_waddr),
        .o_tx_wdata   (tx_wdata),
        .o_tx_raddr   (tx_raddr)
    );

    i2ctbc_ram #(
        .WIDTH (i2ctbc_pkg::BYTE_W),
        .DEPTH (i2ctbc_pkg::RX_DEPTH)
    ) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_waddr (rx_waddr),
        .i_wdata (rx_wdata),
        .i_raddr (rx_raddr),
        .o_rdata (rx_rdata)
    );

    i2ctbc_ram #(
        .WIDTH (i2ctbc_pkg::BYTE_W),
        .DEPTH (i2ctbc_pkg::TX_DEPTH)
    ) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_waddr (tx_waddr),
        .i_wdata (tx_wdata),
        .i_raddr (tx_raddr),
        .o_rdata (tx_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_live  <= 1'b1;
            r_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= res;
        end
    end

    assign o_result_valid   = r_valid;
    assign o_load_shift     = r_res.load_shift;
    assign o_shift_value    = r_res.use_tx ? tx_rdata : 8'h00;
    assign o_sda_drive      = r_res.sda_drive;
    assign o_shift_bits     = r_res.shift_bits;
    assign o_wait_for_start = r_res.wait_for_start;
    assign o_read_request   = r_res.read_request;
    assign o_pop_valid      = r_res.pop_valid;
    assign o_pop_byte       = r_res.pop_valid ? rx_rdata : 8'h00;
    assign o_push_dropped   = r_res.push_dropped;
    assign o_rx_overrun     = r_res.rx_overrun;
    assign o_rx_level       = r_res.rx_level;
    assign o_tx_level       = r_res.tx_level;

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_result_valid)
        else $error("accepted item gave no result");

    a_overrun_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_rx_overrun) |->
            (o_rx_level == i2ctbc_pkg::LEVEL_W'(i2ctbc_pkg::RX_DEPTH)))
        else $error("overrun with receive FIFO not full");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_push_dropped) |->
            (o_tx_level == i2ctbc_pkg::LEVEL_W'(i2ctbc_pkg::TX_DEPTH)))
        else $error("push dropped with transmit FIFO not full");

    a_read_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_read_request) |-> !o_wait_for_start)
        else $error("read request with bus released");

    a_data_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_sda_drive && o_shift_bits == i2ctbc_pkg::BITS_BYTE)
            |-> o_load_shift)
        else $error("data drive without shifter load");

endmodule

// ----- sv/i2ctbc_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module i2ctbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/i2ctbc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C target byte sequencer control
// Phase machine, bus arming, own address and FIFO pointers; drives the RAMs.
// ----------------------------------------------------------------------------
module i2ctbc_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  i2ctbc_pkg::t_cmd                i_command,
    input  logic [i2ctbc_pkg::BYTE_W-1:0]   i_shift_byte,
    input  logic                            i_stop_seen,
    input  logic [i2ctbc_pkg::BYTE_W-1:0]   i_host_byte,
    input  logic                            i_cfg_we,
    input  logic [i2ctbc_pkg::ADDR_W-1:0]   i_cfg_wdata,
    output i2ctbc_pkg::t_result             o_result,
    output logic                            o_rx_we,
    output logic [i2ctbc_pkg::RX_AW-1:0]    o_rx_waddr,
    output logic [i2ctbc_pkg::BYTE_W-1:0]   o_rx_wdata,
    output logic [i2ctbc_pkg::RX_AW-1:0]    o_rx_raddr,
    output logic                            o_tx_we,
    output logic [i2ctbc_pkg::TX_AW-1:0]    o_tx_waddr,
    output logic [i2ctbc_pkg::BYTE_W-1:0]   o_tx_wdata,
    output logic [i2ctbc_pkg::TX_AW-1:0]    o_tx_raddr
);

    localparam int RX_AW = i2ctbc_pkg::RX_AW;
    localparam int TX_AW = i2ctbc_pkg::TX_AW;
    localparam int RX_LW = i2ctbc_pkg::RX_LW;
    localparam int TX_LW = i2ctbc_pkg::TX_LW;
    localparam int LEVEL_W = i2ctbc_pkg::LEVEL_W;

    i2ctbc_pkg::t_phase                r_phase, n_phase;
    logic                              r_armed, n_armed;
    logic [i2ctbc_pkg::ADDR_W-1:0]     r_own_addr;
    logic [RX_AW-1:0]                  r_rx_wr, n_rx_wr, r_rx_rd, n_rx_rd;
    logic [RX_LW-1:0]                  r_rx_fill, n_rx_fill;
    logic [TX_AW-1:0]                  r_tx_wr, n_tx_wr, r_tx_rd, n_tx_rd;
    logic [TX_LW-1:0]                  r_tx_fill, n_tx_fill;
    i2ctbc_pkg::t_result               res;
    logic                              rx_we, tx_we;
    logic                              tx_empty, tx_full, rx_empty, rx_full;

    assign tx_empty = (r_tx_fill == '0);
    assign rx_empty = (r_rx_fill == '0);
    assign tx_full  = (r_tx_fill == TX_LW'(i2ctbc_pkg::TX_DEPTH));
    assign rx_full  = (r_rx_fill == RX_LW'(i2ctbc_pkg::RX_DEPTH));

    function automatic logic [RX_AW-1:0] rx_next(input logic [RX_AW-1:0] p);
        rx_next = (p == RX_AW'(i2ctbc_pkg::RX_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [TX_AW-1:0] tx_next(input logic [TX_AW-1:0] p);
        tx_next = (p == TX_AW'(i2ctbc_pkg::TX_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= i2ctbc_pkg::PH_ADDR;
            r_armed    <= 1'b0;
            r_own_addr <= '0;
            r_rx_wr    <= '0;
            r_rx_rd    <= '0;
            r_rx_fill  <= '0;
            r_tx_wr    <= '0;
            r_tx_rd    <= '0;
            r_tx_fill  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_own_addr <= i_cfg_wdata;
            end
            if (i_accept) begin
                r_phase   <= n_phase;
                r_armed   <= n_armed;
                r_rx_wr   <= n_rx_wr;
                r_rx_rd   <= n_rx_rd;
                r_rx_fill <= n_rx_fill;
                r_tx_wr   <= n_tx_wr;
                r_tx_rd   <= n_tx_rd;
                r_tx_fill <= n_tx_fill;
            end
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_armed   = r_armed;
        n_rx_wr   = r_rx_wr;
        n_rx_rd   = r_rx_rd;
        n_rx_fill = r_rx_fill;
        n_tx_wr   = r_tx_wr;
        n_tx_rd   = r_tx_rd;
        n_tx_fill = r_tx_fill;
        rx_we     = 1'b0;
        tx_we     = 1'b0;
        res       = '0;
        res.shift_bits = i2ctbc_pkg::BITS_BYTE;

        unique case (i_command)
            i2ctbc_pkg::CMD_START: begin
                n_phase = i2ctbc_pkg::PH_ADDR;
                n_armed = !i_stop_seen;
            end
            i2ctbc_pkg::CMD_SHIFT: begin
                if (r_armed) begin
                    unique case (r_phase) inside
                        i2ctbc_pkg::PH_ADDR: begin
                            if (i_shift_byte[6:1] == r_own_addr) begin
                                if (i_shift_byte[0]) begin
                                    res.read_request = 1'b1;
                                    n_phase = i2ctbc_pkg::PH_SEND;
                                end else begin
                                    n_phase = i2ctbc_pkg::PH_REQ_DATA;
                                end
                                res.load_shift = 1'b1;
                                res.sda_drive  = 1'b1;
                                res.shift_bits = i2ctbc_pkg::BITS_ACK;
                            end else begin
                                n_armed = 1'b0;
                            end
                        end
                        i2ctbc_pkg::PH_SEND, i2ctbc_pkg::PH_CHK_REPLY: begin
                            if (r_phase == i2ctbc_pkg::PH_CHK_REPLY && i_shift_byte != '0) begin
                                // master NACK
                                n_armed = 1'b0;
                            end else if (!tx_empty) begin
                                res.load_shift = 1'b1;
                                res.use_tx     = 1'b1;
                                res.sda_drive  = 1'b1;
                                n_tx_rd   = tx_next(r_tx_rd);
                                n_tx_fill = r_tx_fill - 1'b1;
                                n_phase   = i2ctbc_pkg::PH_REQ_REPLY;
                            end else begin
                                res.load_shift = 1'b1;
                                n_armed = 1'b0;
                            end
                        end
                        i2ctbc_pkg::PH_REQ_REPLY: begin
                            n_phase = i2ctbc_pkg::PH_CHK_REPLY;
                            res.load_shift = 1'b1;
                            res.shift_bits = i2ctbc_pkg::BITS_ACK;
                        end
                        i2ctbc_pkg::PH_REQ_DATA: begin
                            n_phase = i2ctbc_pkg::PH_GET_DATA;
                        end
                        i2ctbc_pkg::PH_GET_DATA: begin
                            if (!rx_full) begin
                                rx_we     = 1'b1;
                                n_rx_wr   = rx_next(r_rx_wr);
                                n_rx_fill = r_rx_fill + 1'b1;
                            end else begin
                                res.rx_overrun = 1'b1;
                            end
                            n_phase = i2ctbc_pkg::PH_REQ_DATA;
                            res.load_shift = 1'b1;
                            res.sda_drive  = 1'b1;
                            res.shift_bits = i2ctbc_pkg::BITS_ACK;
                        end
                        default: begin
                            n_phase = i2ctbc_pkg::PH_ADDR;
                            n_armed = 1'b0;
                        end
                    endcase
                end
            end
            i2ctbc_pkg::CMD_PUSH: begin
                if (!tx_full) begin
                    tx_we     = 1'b1;
                    n_tx_wr   = tx_next(r_tx_wr);
                    n_tx_fill = r_tx_fill + 1'b1;
                end else begin
                    res.push_dropped = 1'b1;
                end
            end
            i2ctbc_pkg::CMD_POP: begin
                if (!rx_empty) begin
                    res.pop_valid = 1'b1;
                    n_rx_rd   = rx_next(r_rx_rd);
                    n_rx_fill = r_rx_fill - 1'b1;
                end
            end
            default: begin
            end
        endcase

        res.wait_for_start = !n_armed;
        res.rx_level       = LEVEL_W'(n_rx_fill);
        res.tx_level       = LEVEL_W'(n_tx_fill);
    end

    assign o_result   = res;
    assign o_rx_we    = i_accept && rx_we;
    assign o_rx_waddr = r_rx_wr;
    assign o_rx_wdata = i_shift_byte;
    assign o_rx_raddr = r_rx_rd;
    assign o_tx_we    = i_accept && tx_we;
    assign o_tx_waddr = r_tx_wr;
    assign o_tx_wdata = i_host_byte;
    assign o_tx_raddr = r_tx_rd;

endmodule
